/* hw/rtl/cdb_pkg.sv */
// Shared types, codes and helpers for the card directory block chain engine.
package cdb_pkg;

  localparam int NAME_W = 160;
  localparam int IDX_W  = 4;
  localparam logic [IDX_W-1:0] NO_NEXT = 4'd15;

  typedef enum logic [1:0] {
    CMD_FORMAT = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_MAP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FREE   = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_LAST   = 2'd3
  } entry_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_PAST_END  = 3'd4
  } status_t;

  typedef struct packed {
    entry_kind_t       kind;
    logic [IDX_W-1:0]  next;
    logic [NAME_W-1:0] name;
  } entry_t;

  // Every byte after the first zero byte of the name is forced to zero.
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] n);
    logic ended;
    logic [NAME_W-1:0] r;
    ended = 1'b0;
    r = '0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      r[8*i +: 8] = ended ? 8'd0 : n[8*i +: 8];
      if (n[8*i +: 8] == 8'd0) ended = 1'b1;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/card_directory_block_chain_engine.sv */
// Top level: directory sequencer around the entry memory.
// Format clears the valid flags; create scans the names, then allocates block_count entries.
// Delete and map: a name scan that stops at a match or the last entry, then a read and a step per chain link.
// One command is processed at a time; the entry memory's single read port sets the pace.
// Reset (rst, synchronous) marks every entry free at once through per-entry valid flags.
// A new item is taken only when the previous command has issued all of its results.
module card_directory_block_chain_engine #(
  parameter int NUM_BLOCKS  = 15,
  parameter int BLOCK_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] name_bytes_0_7,
  input  logic [63:0] name_bytes_8_15,
  input  logic [31:0] name_bytes_16_19,
  input  logic [4:0]  block_count,
  input  logic [16:0] byte_offset,
  input  logic [16:0] byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  block_index,
  output logic [12:0] start_offset,
  output logic [13:0] segment_bytes,
  output logic        last
);
  import cdb_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam logic [16:0] BB = 17'(BLOCK_BYTES);
  localparam logic [IDX_W:0] NB = (IDX_W+1)'(NUM_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE, S_FORMAT, S_SCAN, S_DECIDE, S_ALLOC, S_WREAD, S_WSTEP, S_RESULT
  } state_t;

  state_t state;
  cmd_t cmd;
  logic [NAME_W-1:0] name;
  logic [4:0] want;
  logic [16:0] at;
  logic [16:0] left;
  logic [NUM_BLOCKS-1:0] valid_bits;
  logic [NUM_BLOCKS-1:0] free_work;
  logic [IDX_W-1:0] scan_idx, chk_idx, head, cur, steps, res_block;
  logic chk_v, found;
  logic [4:0] alloc_i;
  status_t res_status;

  entry_t rd_entry, wr_entry;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;

  function automatic logic [IDX_W-1:0] lowest(input logic [NUM_BLOCKS-1:0] m);
    logic [IDX_W-1:0] r;
    r = NO_NEXT;
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      if (m[b]) r = IDX_W'(b);
    end
    return r;
  endfunction

  logic out_free, out_load, scan_match, scan_done, scan_issue;
  logic [IDX_W-1:0] cur_blk, nxt_blk;
  logic [NUM_BLOCKS-1:0] cur_mask;
  logic [IDX_W:0] free_cnt, steps_inc;
  logic [13:0] room, cnt;
  logic [16:0] left_n;
  logic chain_more;

  always_comb begin
    out_free   = !out_valid || !out_stall;
    out_load   = out_free && (state == S_RESULT ||
                              (state == S_WSTEP && cmd == CMD_MAP && at < BB));
    scan_match = chk_v && valid_bits[chk_idx[AW-1:0]] && rd_entry.kind == KIND_FIRST &&
                 rd_entry.name == name;
    scan_done  = chk_v && (scan_match || chk_idx == NB[IDX_W-1:0] - 1'b1);
    scan_issue = state == S_SCAN && (IDX_W+1)'(scan_idx) < NB && !scan_done;
    cur_blk    = lowest(free_work);
    cur_mask   = '0;
    cur_mask[cur_blk[AW-1:0]] = 1'b1;
    nxt_blk    = lowest(free_work & ~cur_mask);
    free_cnt   = (IDX_W+1)'($countones(~valid_bits));
    steps_inc  = (IDX_W+1)'(steps) + 1'b1;
    room       = 14'(BB - at);
    cnt        = ({3'd0, room} < left) ? room : left[13:0];
    left_n     = left - 17'(cnt);
    chain_more = steps_inc < NB && (IDX_W+1)'(rd_entry.next) < NB;

    wr_entry.kind = (alloc_i == 5'd0) ? KIND_FIRST :
                    (alloc_i + 5'd1 < want) ? KIND_MIDDLE : KIND_LAST;
    wr_entry.next = (alloc_i + 5'd1 < want) ? nxt_blk : NO_NEXT;
    wr_entry.name = (alloc_i == 5'd0) ? name : '0;
    ram_we    = state == S_ALLOC;
    ram_waddr = cur_blk[AW-1:0];
    ram_re    = scan_issue || state == S_WREAD;
    ram_raddr = (state == S_WREAD) ? cur[AW-1:0] : scan_idx[AW-1:0];
  end

  cdb_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_BLOCKS)) u_entries (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wr_entry),
    .re(ram_re), .raddr(ram_raddr), .rdata(rd_entry)
  );

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      valid_bits <= '0;
      chk_v      <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      chk_v   <= scan_issue;
      chk_idx <= scan_idx;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd      <= cmd_t'(kind);
            name     <= clean_name({name_bytes_16_19, name_bytes_8_15, name_bytes_0_7});
            want     <= block_count;
            at       <= byte_offset;
            left     <= byte_count;
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= (cmd_t'(kind) == CMD_FORMAT) ? S_FORMAT : S_SCAN;
          end
        end
        S_FORMAT: begin
          valid_bits <= '0;
          res_status <= ST_OK;
          res_block  <= '0;
          state      <= S_RESULT;
        end
        S_SCAN: begin
          if (scan_issue) scan_idx <= scan_idx + 1'b1;
          if (scan_match) begin
            found <= 1'b1;
            head  <= chk_idx;
          end
          if (scan_done) state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_block <= '0;
          res_status <= ST_OK;
          cur   <= head;
          steps <= '0;
          priority if (cmd == CMD_CREATE) begin
            if (found) begin
              res_status <= ST_EXISTS;
              state      <= S_RESULT;
            end else if (want == 5'd0 || want > 5'(free_cnt)) begin
              res_status <= ST_FULL;
              state      <= S_RESULT;
            end else begin
              free_work <= ~valid_bits;
              alloc_i   <= '0;
              state     <= S_ALLOC;
            end
          end else if (!found) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_RESULT;
          end else if (cmd == CMD_MAP && left == 17'd0) begin
            state <= S_RESULT;
          end else begin
            state <= S_WREAD;
          end
        end
        S_ALLOC: begin
          valid_bits[cur_blk[AW-1:0]] <= 1'b1;
          free_work[cur_blk[AW-1:0]]  <= 1'b0;
          alloc_i <= alloc_i + 1'b1;
          if (alloc_i == 5'd0) res_block <= cur_blk;
          if (alloc_i + 5'd1 == want) state <= S_RESULT;
        end
        S_WREAD: begin
          state <= S_WSTEP;
        end
        S_WSTEP: begin
          if (cmd == CMD_DELETE) begin
            valid_bits[cur[AW-1:0]] <= 1'b0;
            steps <= steps + 1'b1;
            cur   <= rd_entry.next;
            state <= chain_more ? S_WREAD : S_RESULT;
          end else if (at < BB) begin
            if (out_free) begin
              status        <= ST_OK;
              block_index   <= cur;
              start_offset  <= at[12:0];
              segment_bytes <= cnt;
              last          <= left_n == 17'd0;
              left  <= left_n;
              at    <= '0;
              steps <= steps + 1'b1;
              cur   <= rd_entry.next;
              res_status <= ST_PAST_END;
              priority if (left_n == 17'd0) state <= S_IDLE;
              else if (chain_more) state <= S_WREAD;
              else state <= S_RESULT;
            end
          end else begin
            at    <= at - BB;
            steps <= steps + 1'b1;
            cur   <= rd_entry.next;
            res_status <= ST_PAST_END;
            state <= chain_more ? S_WREAD : S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            status        <= res_status;
            block_index   <= res_block;
            start_offset  <= '0;
            segment_bytes <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_alloc_has_free: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> free_work != '0) else $error("allocation without a free block");
  a_alloc_target_free: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> !valid_bits[cur_blk[AW-1:0]]) else $error("allocating a used block");
  a_map_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == S_WSTEP && cmd == CMD_MAP) |-> left != 17'd0) else $error("map walk with no bytes");
  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_v |-> state == S_SCAN) else $error("compare outside the name scan");
endmodule

/* hw/rtl/cdb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
